>>> rtl/sdp_pkg.sv
// Shared types, constants and the saturating product helper for the SPH density block.
package sdp_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int POW_EXP         = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_LEN_SQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_REST_DENSITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAS_STIFFNESS    = 3'd4;

    localparam logic [31:0] RST_SMOOTH_LEN_SQ    = 32'h0001_0000;
    localparam logic [15:0] RST_MIN_DIST_SQ      = 16'h0001;
    localparam logic [31:0] RST_DENSITY_SCALE    = 32'h0001_0000;
    localparam logic [31:0] RST_INV_REST_DENSITY = 32'h0001_0000;
    localparam logic [31:0] RST_GAS_STIFFNESS    = 32'h0001_0000;

    localparam logic [63:0] SAT64        = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK32       = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] PRES_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] PRES_NEG_MAG = 64'h0000_0000_8000_0000;

    typedef struct packed {
        logic [31:0] smooth_len_sq;
        logic [15:0] min_dist_sq;
        logic [31:0] density_scale;
        logic [31:0] inv_rest_density;
        logic [31:0] gas_stiffness;
    } t_cfg;

    // classified pair: d = h2 - r2 when hit
    typedef struct packed {
        logic [31:0] d;
        logic        hit;
        logic        last;
    } t_pair;

    typedef struct packed {
        logic        start;
        logic [63:0] sum;
    } t_fin_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_fin_stat;

    // floor((p0 + p1*2^32) / 2^frac), saturated to 64 bits
    function automatic logic [63:0] f_mul_combine(input logic [63:0] p0,
                                                  input logic [63:0] p1,
                                                  input int unsigned frac);
        logic [95:0] full;
        logic [95:0] top;
        logic [95:0] shifted;
        full    = {32'd0, p0} + {p1, 32'd0};
        top     = full >> (64 + frac);
        shifted = full >> frac;
        if (top != 96'd0) begin
            return SAT64;
        end
        return shifted[63:0];
    endfunction

endpackage

>>> rtl/sph_density_pressure.sv
// SPH poly6 density and Tait pressure: top level with configuration registers.
//
// Input channel: one neighbour word per particle pair (centre position, neighbour
// position, last flag) on i_in_valid / o_in_stall; a word is taken when valid is high
// and stall is low. Words stream at one per cycle while o_in_stall is low: the front
// forms r2 in three stages and drops pairs outside the kernel, the back turns each
// counted pair into (h2 - r2)^3 in a five stage pipe and adds it into the kernel sum.
// Output channel: one word (density, pressure) per run, on o_out_valid / i_out_stall,
// held in an output register until taken.
// The finish step runs nine 64x32 products (three when the density ratio overflows 32
// bits) on a single 32x32 multiplier, each through the states S_MLO, S_MHI, S_MCMB
// and S_STEP. Words of the next run keep flowing meanwhile; its last word waits in the
// queue until the previous result is in the output register, and a full queue raises
// o_in_stall while the front holds a pair to push into it. A stalled output stops the
// finish sequencer at its final step only. Reset (i_rst_n low, synchronous) clears the
// sum, the pipes and the queue and loads the register defaults; configuration writes
// on i_cfg_wr_en are registered in r_cfg.
module sph_density_pressure
    import sdp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [31:0]    i_center_x,
    input  logic signed [31:0]    i_center_y,
    input  logic signed [31:0]    i_neighbour_x,
    input  logic signed [31:0]    i_neighbour_y,
    input  logic                  i_last_neighbour,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic        [31:0]    o_density,
    output logic signed [31:0]    o_pressure
);

    t_cfg      r_cfg;
    logic      q_push;
    t_pair     q_push_word;
    logic      q_full;
    logic      q_valid;
    t_pair     q_word;
    logic      q_pop;
    t_fin_ctl  fin_ctl;
    t_fin_stat fin_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth_len_sq    <= RST_SMOOTH_LEN_SQ;
            r_cfg.min_dist_sq      <= RST_MIN_DIST_SQ;
            r_cfg.density_scale    <= RST_DENSITY_SCALE;
            r_cfg.inv_rest_density <= RST_INV_REST_DENSITY;
            r_cfg.gas_stiffness    <= RST_GAS_STIFFNESS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SMOOTH_LEN_SQ:    r_cfg.smooth_len_sq    <= i_cfg_wdata;
                CFG_MIN_DIST_SQ:      r_cfg.min_dist_sq      <= i_cfg_wdata[15:0];
                CFG_DENSITY_SCALE:    r_cfg.density_scale    <= i_cfg_wdata;
                CFG_INV_REST_DENSITY: r_cfg.inv_rest_density <= i_cfg_wdata;
                CFG_GAS_STIFFNESS:    r_cfg.gas_stiffness    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    sdp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_center_x       (i_center_x),
        .i_center_y       (i_center_y),
        .i_neighbour_x    (i_neighbour_x),
        .i_neighbour_y    (i_neighbour_y),
        .i_last_neighbour (i_last_neighbour),
        .o_push           (q_push),
        .o_push_word      (q_push_word),
        .i_q_full         (q_full)
    );

    sdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_word (q_push_word),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_word      (q_word),
        .i_pop       (q_pop)
    );

    sdp_kernel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_kernel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_word   (q_word),
        .o_q_pop    (q_pop),
        .i_fin_stat (fin_stat),
        .o_fin_ctl  (fin_ctl)
    );

    sdp_final #(
        .FRAC_BITS (FRAC_BITS)
    ) u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fin_ctl   (fin_ctl),
        .o_fin_stat  (fin_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_density   (o_density),
        .o_pressure  (o_pressure)
    );

`ifndef SYNTHESIS
    // a run may only close while the finish sequencer is free
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_ctl.start |-> !fin_stat.busy)
        else $error("run closed while finish sequencer busy");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_stat.done |=> o_out_valid)
        else $error("finished result not in output register");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

>>> rtl/sdp_front.sv
// Front end: takes neighbour words, forms r2, classifies and pushes pairs to the queue.
module sdp_front
    import sdp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_neighbour_x,
    input  logic signed [31:0] i_neighbour_y,
    input  logic               i_last_neighbour,
    output logic               o_push,
    output t_pair              o_push_word,
    input  logic               i_q_full
);

    localparam int R2_W = 65 - FRAC_BITS;

    logic [32:0]     dx;
    logic [32:0]     dy;
    logic [31:0]     ax;
    logic [31:0]     ay;
    logic            adv;
    logic            accept;
    logic [64:0]     sum_sq;
    logic [R2_W-1:0] r2;
    logic            hit;

    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_s1_ax, r_s1_ay;
    logic        r_s1_last;
    logic [63:0] r_s2_sx, r_s2_sy;
    logic        r_s2_last;
    t_pair       r_s3_word;
    logic        r_s3_keep;

    always_comb begin
        dx = {i_neighbour_x[31], i_neighbour_x} - {i_center_x[31], i_center_x};
        dy = {i_neighbour_y[31], i_neighbour_y} - {i_center_y[31], i_center_y};
        ax = dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
        ay = dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
    end

    // pairs outside the kernel that do not close a run are dropped here
    assign adv    = !(r_v3 && r_s3_keep && i_q_full);
    assign accept = i_in_valid && adv;

    assign sum_sq = {1'b0, r_s2_sx} + {1'b0, r_s2_sy};
    assign r2     = sum_sq[64:FRAC_BITS];
    assign hit    = (r2 < R2_W'(i_cfg.smooth_len_sq)) && (r2 >= R2_W'(i_cfg.min_dist_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ax        <= ax;
            r_s1_ay        <= ay;
            r_s1_last      <= i_last_neighbour;
            r_s2_sx        <= 64'(r_s1_ax) * 64'(r_s1_ax);
            r_s2_sy        <= 64'(r_s1_ay) * 64'(r_s1_ay);
            r_s2_last      <= r_s1_last;
            r_s3_word.d    <= i_cfg.smooth_len_sq - r2[31:0];
            r_s3_word.hit  <= hit;
            r_s3_word.last <= r_s2_last;
            r_s3_keep      <= hit || r_s2_last;
        end
    end

    assign o_in_stall  = !adv;
    assign o_push      = r_v3 && r_s3_keep && !i_q_full;
    assign o_push_word = r_s3_word;

endmodule

>>> rtl/sdp_queue.sv
// Short register FIFO of classified pairs between front and back.
module sdp_queue
    import sdp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_push_word,
    output logic  o_full,
    output logic  o_valid,
    output t_pair o_word,
    input  logic  i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pair            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

endmodule

>>> rtl/sdp_kernel.sv
// Back end kernel pipe: (h2 - r2)^3 per pair and the saturating kernel sum.
module sdp_kernel
    import sdp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_pair     i_q_word,
    output logic      o_q_pop,
    input  t_fin_stat i_fin_stat,
    output t_fin_ctl  o_fin_ctl
);

    logic        pop;
    logic [63:0] sq;
    logic [64:0] sum_ext;
    logic [63:0] acc;

    logic        r_hold, n_hold;
    logic        r_k1_v, r_k2_v, r_k3_v, r_k4_v, r_k5_v;
    logic        r_k1_hit, r_k2_hit, r_k3_hit, r_k4_hit, r_k5_hit;
    logic        r_k1_last, r_k2_last, r_k3_last, r_k4_last, r_k5_last;
    logic [31:0] r_k1_d, r_k2_d, r_k3_d;
    logic [63:0] r_k2_dd;
    logic [31:0] r_k3_sq_hi;
    logic [63:0] r_k3_p0, r_k4_p0;
    logic [63:0] r_k4_p1;
    logic [63:0] r_k5_term;
    logic [63:0] r_sum;

    // one run closes at a time: a closing word waits until the previous result is out
    assign pop = i_q_valid && !(i_q_word.last && r_hold);
    assign sq  = r_k2_dd >> FRAC_BITS;

    assign sum_ext = {1'b0, r_sum} + {1'b0, r_k5_term};
    assign acc     = !r_k5_hit ? r_sum : (sum_ext[64] ? SAT64 : sum_ext[63:0]);

    always_comb begin
        n_hold = r_hold;
        priority if (pop && i_q_word.last) begin
            n_hold = 1'b1;
        end else if (i_fin_stat.done) begin
            n_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_k1_v <= 1'b0;
            r_k2_v <= 1'b0;
            r_k3_v <= 1'b0;
            r_k4_v <= 1'b0;
            r_k5_v <= 1'b0;
            r_sum  <= '0;
        end else begin
            r_hold <= n_hold;
            r_k1_v <= pop;
            r_k2_v <= r_k1_v;
            r_k3_v <= r_k2_v;
            r_k4_v <= r_k3_v;
            r_k5_v <= r_k4_v;
            if (r_k5_v) begin
                r_sum <= r_k5_last ? '0 : acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k1_d     <= i_q_word.d;
        r_k1_hit   <= i_q_word.hit;
        r_k1_last  <= i_q_word.last;
        r_k2_dd    <= 64'(r_k1_d) * 64'(r_k1_d);
        r_k2_d     <= r_k1_d;
        r_k2_hit   <= r_k1_hit;
        r_k2_last  <= r_k1_last;
        r_k3_p0    <= 64'(sq[31:0]) * 64'(r_k2_d);
        r_k3_sq_hi <= sq[63:32];
        r_k3_d     <= r_k2_d;
        r_k3_hit   <= r_k2_hit;
        r_k3_last  <= r_k2_last;
        r_k4_p1    <= 64'(r_k3_sq_hi) * 64'(r_k3_d);
        r_k4_p0    <= r_k3_p0;
        r_k4_hit   <= r_k3_hit;
        r_k4_last  <= r_k3_last;
        r_k5_term  <= f_mul_combine(r_k4_p0, r_k4_p1, FRAC_BITS);
        r_k5_hit   <= r_k4_hit;
        r_k5_last  <= r_k4_last;
    end

    assign o_q_pop         = pop;
    assign o_fin_ctl.start = r_k5_v && r_k5_last;
    assign o_fin_ctl.sum   = acc;

endmodule

>>> rtl/sdp_final.sv
// Back end finish sequencer: density, ratio power and Tait pressure on one multiplier.
module sdp_final
    import sdp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_fin_ctl           i_fin_ctl,
    output t_fin_stat          o_fin_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic        [31:0] o_density,
    output logic signed [31:0] o_pressure
);

    localparam int          CNT_W = $clog2(POW_EXP - 1);
    localparam logic [63:0] ONE   = 64'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MLO,
        S_MHI,
        S_MCMB,
        S_STEP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_DENS,
        OP_RATIO,
        OP_POW,
        OP_PRES
    } t_op;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [63:0]        r_ma, n_ma;
    logic [31:0]        r_mb, n_mb;
    logic [63:0]        r_p0, n_p0;
    logic [63:0]        r_p1, n_p1;
    logic [63:0]        r_res, n_res;
    logic               r_neg, n_neg;
    logic [31:0]        r_dens, n_dens;
    logic [31:0]        r_ratio, n_ratio;
    logic [31:0]        r_pres, n_pres;
    logic               r_out_v, n_out_v;
    logic [31:0]        r_density, n_density;
    logic signed [31:0] r_pressure, n_pressure;

    logic [31:0] mul_a;
    logic [63:0] prod;
    logic [31:0] dens32;
    logic        do_pres;
    logic [63:0] pw_in;
    logic        pw_ge;
    logic        load;

    assign mul_a = (r_state == S_MLO) ? r_ma[31:0] : r_ma[63:32];
    assign prod  = 64'(mul_a) * 64'(r_mb);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_cnt      = r_cnt;
        n_ma       = r_ma;
        n_mb       = r_mb;
        n_p0       = r_p0;
        n_p1       = r_p1;
        n_res      = r_res;
        n_neg      = r_neg;
        n_dens     = r_dens;
        n_ratio    = r_ratio;
        n_pres     = r_pres;
        n_out_v    = r_out_v;
        n_density  = r_density;
        n_pressure = r_pressure;
        dens32     = (r_res > MASK32) ? 32'hFFFF_FFFF : r_res[31:0];
        do_pres    = 1'b0;
        pw_in      = r_res;
        pw_ge      = 1'b0;
        load       = 1'b0;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_fin_ctl.start) begin
                    n_ma    = i_fin_ctl.sum;
                    n_mb    = i_cfg.density_scale;
                    n_op    = OP_DENS;
                    n_state = S_MLO;
                end
            end
            S_MLO: begin
                n_p0    = prod;
                n_state = S_MHI;
            end
            S_MHI: begin
                n_p1    = prod;
                n_state = S_MCMB;
            end
            S_MCMB: begin
                n_res   = f_mul_combine(r_p0, r_p1, FRAC_BITS);
                n_state = S_STEP;
            end
            S_STEP: begin
                unique case (r_op)
                    OP_DENS: begin
                        n_dens  = dens32;
                        n_ma    = {32'd0, dens32};
                        n_mb    = i_cfg.inv_rest_density;
                        n_op    = OP_RATIO;
                        n_state = S_MLO;
                    end
                    OP_RATIO: begin
                        if (r_res[63:32] != 32'd0) begin
                            // ratio beyond 32 bits: power taken as all ones
                            pw_in   = SAT64;
                            do_pres = 1'b1;
                        end else begin
                            n_ratio = r_res[31:0];
                            n_ma    = r_res;
                            n_mb    = r_res[31:0];
                            n_cnt   = '0;
                            n_op    = OP_POW;
                            n_state = S_MLO;
                        end
                    end
                    OP_POW: begin
                        if (r_cnt == CNT_W'(POW_EXP - 2)) begin
                            do_pres = 1'b1;
                        end else begin
                            n_ma    = r_res;
                            n_mb    = r_ratio;
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = S_MLO;
                        end
                    end
                    OP_PRES: begin
                        if (r_neg) begin
                            n_pres = (r_res > PRES_NEG_MAG) ? PRES_NEG_MAG[31:0]
                                                            : (~r_res[31:0] + 32'd1);
                        end else begin
                            n_pres = (r_res > PRES_POS_MAX) ? PRES_POS_MAX[31:0]
                                                            : r_res[31:0];
                        end
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!r_out_v || !i_out_stall) begin
                    load       = 1'b1;
                    n_out_v    = 1'b1;
                    n_density  = r_dens;
                    n_pressure = $signed(r_pres);
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // magnitude of pow - 1, sign kept apart
        if (do_pres) begin
            pw_ge   = (pw_in >= ONE);
            n_ma    = pw_ge ? (pw_in - ONE) : (ONE - pw_in);
            n_neg   = !pw_ge;
            n_mb    = i_cfg.gas_stiffness;
            n_op    = OP_PRES;
            n_state = S_MLO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_v    <= n_out_v;
            r_op       <= n_op;
            r_cnt      <= n_cnt;
            r_ma       <= n_ma;
            r_mb       <= n_mb;
            r_p0       <= n_p0;
            r_p1       <= n_p1;
            r_res      <= n_res;
            r_neg      <= n_neg;
            r_dens     <= n_dens;
            r_ratio    <= n_ratio;
            r_pres     <= n_pres;
            r_density  <= n_density;
            r_pressure <= n_pressure;
        end
    end

    assign o_fin_stat.busy = (r_state != S_IDLE);
    assign o_fin_stat.done = load;
    assign o_out_valid     = r_out_v;
    assign o_density       = r_density;
    assign o_pressure      = r_pressure;

endmodule
